[rtl/bcd_alarm_time_offset_assert.svh]
// ----------------------------------------------------------------------------
// BCD alarm time offset assertion macros
// Clocked implication checks used by the asserting file bcd_alarm_time_offset.sv.
// ----------------------------------------------------------------------------
`ifndef BCD_ALARM_TIME_OFFSET_ASSERT_SVH
`define BCD_ALARM_TIME_OFFSET_ASSERT_SVH

// same-cycle implication
`define BATO_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bcd_alarm_time_offset: check failed");

// next-cycle implication
`define BATO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bcd_alarm_time_offset: check failed");

`endif

[rtl/bato_pkg.sv]
// ----------------------------------------------------------------------------
// BCD alarm time offset package
// Time-of-week type, BCD wrap constants and alarm mode codes.
// ----------------------------------------------------------------------------
package bato_pkg;

    typedef struct packed {
        logic [7:0] sec;
        logic [7:0] min;
        logic [7:0] hour;
        logic [7:0] day;
    } tow_t;

    localparam logic [7:0] MS_WRAP    = 8'h59;
    localparam logic [7:0] HOUR_WRAP  = 8'h23;
    localparam logic [7:0] DAY_WRAP   = 8'h07;
    localparam logic [7:0] DAY_START  = 8'h01;
    localparam logic [7:0] DONT_CARE  = 8'h80;
    localparam logic [7:0] TENS_MASK  = 8'hF0;
    localparam logic [7:0] TENS_STEP  = 8'h10;

    localparam logic [2:0] MODE_EVERY = 3'd0;
    localparam logic [2:0] MODE_DHMS  = 3'd1;
    localparam logic [2:0] MODE_HMS   = 3'd2;
    localparam logic [2:0] MODE_MS    = 3'd3;
    localparam logic [2:0] MODE_SEC   = 3'd4;

endpackage

[rtl/bato_tick.sv]
// ----------------------------------------------------------------------------
// BCD alarm time offset one-second step unit
// Advances a time of week by one second with BCD digit carries.
// ----------------------------------------------------------------------------
module bato_tick
    import bato_pkg::*;
(
    input  tow_t cur,
    output tow_t nxt
);

    logic [7:0] sec_tens;
    logic [7:0] min_tens;
    logic [7:0] hour_tens;

    assign sec_tens  = (cur.sec & TENS_MASK) + TENS_STEP;
    assign min_tens  = (cur.min & TENS_MASK) + TENS_STEP;
    assign hour_tens = (cur.hour & TENS_MASK) + TENS_STEP;

    always_comb begin
        nxt = cur;
        if (cur.sec != MS_WRAP) begin
            nxt.sec = (cur.sec inside {8'h09, 8'h19, 8'h29, 8'h39, 8'h49}) ?
                      sec_tens : cur.sec + 8'd1;
        end else begin
            nxt.sec = 8'h00;
            if (cur.min != MS_WRAP) begin
                nxt.min = (cur.min inside {8'h09, 8'h19, 8'h29, 8'h39, 8'h49}) ?
                          min_tens : cur.min + 8'd1;
            end else begin
                nxt.min = 8'h00;
                if (cur.hour != HOUR_WRAP) begin
                    nxt.hour = (cur.hour inside {8'h09, 8'h19}) ?
                               hour_tens : cur.hour + 8'd1;
                end else begin
                    nxt.hour = 8'h00;
                    nxt.day  = (cur.day == DAY_WRAP) ? DAY_START : cur.day + 8'd1;
                end
            end
        end
    end

endmodule

[rtl/bato_mask.sv]
// ----------------------------------------------------------------------------
// BCD alarm time offset alarm mask
// Sets the don't-care bit on fields the alarm mode excludes; an unknown mode zeros all bytes and clears written.
// ----------------------------------------------------------------------------
module bato_mask
    import bato_pkg::*;
(
    input  tow_t       tow,
    input  logic [2:0] mode,
    output logic [7:0] alarm_second,
    output logic [7:0] alarm_minute,
    output logic [7:0] alarm_hour,
    output logic [7:0] alarm_day,
    output logic       written
);

    always_comb begin
        alarm_second = tow.sec;
        alarm_minute = tow.min;
        alarm_hour   = tow.hour;
        alarm_day    = tow.day;
        written      = 1'b1;
        case (mode)
            MODE_EVERY: begin
                alarm_second = tow.sec | DONT_CARE;
                alarm_minute = tow.min | DONT_CARE;
                alarm_hour   = tow.hour | DONT_CARE;
                alarm_day    = tow.day | DONT_CARE;
            end
            MODE_DHMS: begin
            end
            MODE_HMS: begin
                alarm_day = tow.day | DONT_CARE;
            end
            MODE_MS: begin
                alarm_hour = tow.hour | DONT_CARE;
                alarm_day  = tow.day | DONT_CARE;
            end
            MODE_SEC: begin
                alarm_minute = tow.min | DONT_CARE;
                alarm_hour   = tow.hour | DONT_CARE;
                alarm_day    = tow.day | DONT_CARE;
            end
            default: begin
                alarm_second = 8'h00;
                alarm_minute = 8'h00;
                alarm_hour   = 8'h00;
                alarm_day    = 8'h00;
                written      = 1'b0;
            end
        endcase
    end

endmodule

[rtl/bcd_alarm_time_offset.sv]
// ----------------------------------------------------------------------------
// BCD alarm time offset
// Advances a BCD time of week by an interval and forms masked alarm bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one request: alarm mode, interval in seconds and
//   the current BCD second, minute, hour and day of week. The m_ channel
//   returns the four alarm bytes and the written flag, one result per
//   request.
//   A request loads a time register and a down counter; a single one-second
//   BCD step unit advances the time once per cycle until the counter is
//   zero. The result is then presented on m_valid, and the next request is
//   taken in the cycle after the result is accepted.
//   s_ready is low from acceptance until the result is taken. While the
//   receiver holds m_ready low, the result and all of its fields hold.
//   Synchronous reset (aresetn low) drops any request in flight and returns
//   to idle with s_ready high.
// ----------------------------------------------------------------------------
`include "bcd_alarm_time_offset_assert.svh"

module bcd_alarm_time_offset
    import bato_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [15:0] s_interval,
    input  logic [6:0]  s_cur_second,
    input  logic [6:0]  s_cur_minute,
    input  logic [5:0]  s_cur_hour,
    input  logic [2:0]  s_cur_day,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_alarm_second,
    output logic [7:0]  m_alarm_minute,
    output logic [7:0]  m_alarm_hour,
    output logic [7:0]  m_alarm_day,
    output logic        m_written
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] count_reg, count_next;
    logic [2:0]  mode_reg, mode_next;
    tow_t        tow_reg, tow_next;
    tow_t        tow_step;

    bato_tick u_tick (
        .cur (tow_reg),
        .nxt (tow_step)
    );

    bato_mask u_mask (
        .tow          (tow_reg),
        .mode         (mode_reg),
        .alarm_second (m_alarm_second),
        .alarm_minute (m_alarm_minute),
        .alarm_hour   (m_alarm_hour),
        .alarm_day    (m_alarm_day),
        .written      (m_written)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        mode_next  = mode_reg;
        tow_next   = tow_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next     = s_mode;
                    count_next    = s_interval;
                    tow_next.sec  = {1'b0, s_cur_second};
                    tow_next.min  = {1'b0, s_cur_minute};
                    tow_next.hour = {2'b00, s_cur_hour};
                    tow_next.day  = {5'b00000, s_cur_day};
                    state_next    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (count_reg == 16'd0) begin
                    state_next = ST_DONE;
                end else begin
                    tow_next   = tow_step;
                    count_next = count_reg - 16'd1;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        mode_reg  <= mode_next;
        tow_reg   <= tow_next;
    end

    `BATO_ASSERT_NEXT(a_load_count, s_valid && s_ready,
        (state_reg == ST_RUN) && (count_reg == $past(s_interval)))
    `BATO_ASSERT_NEXT(a_count_down, (state_reg == ST_RUN) && (count_reg != 16'd0),
        (state_reg == ST_RUN) && (count_reg == $past(count_reg) - 16'd1))
    `BATO_ASSERT_NOW(a_one_in_flight, m_valid, !s_ready)
    `BATO_ASSERT_NOW(a_unwritten_zero, m_valid && !m_written,
        (m_alarm_second == 8'h00) && (m_alarm_minute == 8'h00) &&
        (m_alarm_hour == 8'h00) && (m_alarm_day == 8'h00))

endmodule
